### src/psw_pkg.sv
// Shared constants, types and helper functions of the point-source wave contribution unit.
`default_nettype none
package psw_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int LANES = 4;

    localparam int ATTEN_W = 16;
    localparam logic [ATTEN_W-1:0] ATTEN_Q16 = 16'd66;

    localparam int SQ_IN_W = 66;
    localparam int SQ_ROOT_W = 34;
    localparam int SQRT_STAGES = SQ_ROOT_W;

    localparam int DIV_NW = 49;
    localparam int DIV_DW = SQ_IN_W + ATTEN_W - 32 + 1;
    localparam int DIV_STAGES = DIV_NW;

    localparam int CORDIC_STAGES = 24;
    localparam int CW = 35;
    localparam int ZW = 33;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'h26DD3B6A;

    localparam int LANE_LAT = 7 + SQRT_STAGES + DIV_STAGES + CORDIC_STAGES;

    localparam logic [2:0] CFG_SRC_X = 3'd0;
    localparam logic [2:0] CFG_SRC_Y = 3'd1;
    localparam logic [2:0] CFG_SRC_Z = 3'd2;
    localparam logic [2:0] CFG_FREQ = 3'd3;
    localparam logic [2:0] CFG_OFFSET = 3'd4;
    localparam logic [2:0] CFG_AMP = 3'd5;
    localparam logic [2:0] CFG_SPEED = 3'd6;
    localparam logic [2:0] CFG_TIME = 3'd7;

    typedef struct packed {
        logic [31:0] src_x;
        logic [31:0] src_y;
        logic [31:0] src_z;
        logic [31:0] freq;
        logic [15:0] offset;
        logic [31:0] amp;
        logic [31:0] speed;
        logic [31:0] sim_time;
    } t_cfg;

    function automatic logic [31:0] atan_turns(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'h20000000;
            1: v = 32'h12E4051D;
            2: v = 32'h09FB385B;
            3: v = 32'h051111D4;
            4: v = 32'h028B0D43;
            5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;
            7: v = 32'h00517C55;
            8: v = 32'h0028BE53;
            9: v = 32'h00145F2E;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [CW-1:0] v);
        logic [31:0] r;
        if (v > $signed({{(CW-31){1'b0}}, {31{1'b1}}})) begin
            r = 32'h7FFFFFFF;
        end else if (v < $signed({{(CW-31){1'b1}}, {31{1'b0}}})) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/psw_sqrt.sv
// Pipelined floor square root, one root bit per stage.
`default_nettype none
module psw_sqrt import psw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [SQ_IN_W-1:0]   i_rad,
    output logic [SQ_ROOT_W-1:0] o_root
);
    localparam int RW = SQ_ROOT_W + 2;
    localparam int PW = 2 * SQ_ROOT_W;

    logic [RW-1:0] r_rem [SQRT_STAGES];
    logic [SQ_ROOT_W-1:0] r_root [SQRT_STAGES];
    logic [PW-1:0] r_rad [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_st
        logic [RW-1:0] w_rem_in;
        logic [SQ_ROOT_W-1:0] w_root_in;
        logic [PW-1:0] w_rad_in;
        logic [RW-1:0] w_sh;
        logic [RW-1:0] w_trial;
        logic w_ge;
        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_root_in = '0;
            assign w_rad_in = PW'(i_rad);
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in = r_rad[s-1];
        end
        assign w_sh = {w_rem_in[RW-3:0], w_rad_in[PW-1 -: 2]};
        assign w_trial = {w_root_in, 2'b01};
        assign w_ge = (w_sh >= w_trial);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? (w_sh - w_trial) : w_sh;
                r_root[s] <= {w_root_in[SQ_ROOT_W-2:0], w_ge};
                r_rad[s] <= {w_rad_in[PW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];
endmodule
`default_nettype wire

### src/psw_div.sv
// Pipelined restoring unsigned divider, one quotient bit per stage.
`default_nettype none
module psw_div import psw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_NW-1:0] o_quo
);
    logic [DIV_DW-1:0] r_rem [DIV_STAGES];
    logic [DIV_DW-1:0] r_den [DIV_STAGES];
    logic [DIV_NW-1:0] r_nq [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
        logic [DIV_DW-1:0] w_rem_in;
        logic [DIV_DW-1:0] w_den_in;
        logic [DIV_NW-1:0] w_nq_in;
        logic [DIV_DW:0] w_sh;
        logic [DIV_DW:0] w_dif;
        logic w_ge;
        if (s == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_den_in = i_den;
            assign w_nq_in = i_num;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_nq_in = r_nq[s-1];
        end
        assign w_sh = {w_rem_in, w_nq_in[DIV_NW-1]};
        assign w_ge = (w_sh >= {1'b0, w_den_in});
        assign w_dif = w_sh - {1'b0, w_den_in};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? w_dif[DIV_DW-1:0] : w_sh[DIV_DW-1:0];
                r_den[s] <= w_den_in;
                r_nq[s] <= {w_nq_in[DIV_NW-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_nq[DIV_STAGES-1];
endmodule
`default_nettype wire

### src/psw_cordic.sv
// Pipelined rotation-mode CORDIC over the first quadrant, angles in turns.
`default_nettype none
module psw_cordic import psw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_x0,
    input  logic [29:0]          i_z0,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y
);
    logic signed [CW-1:0] r_x [CORDIC_STAGES];
    logic signed [CW-1:0] r_y [CORDIC_STAGES];
    logic signed [ZW-1:0] r_z [CORDIC_STAGES];

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_st
        logic signed [CW-1:0] w_x;
        logic signed [CW-1:0] w_y;
        logic signed [ZW-1:0] w_z;
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;
        logic signed [ZW-1:0] w_at;
        if (s == 0) begin : g_first
            assign w_x = $signed(CW'(i_x0));
            assign w_y = '0;
            assign w_z = $signed(ZW'(i_z0));
        end else begin : g_next
            assign w_x = r_x[s-1];
            assign w_y = r_y[s-1];
            assign w_z = r_z[s-1];
        end
        assign w_xs = w_x >>> s;
        assign w_ys = w_y >>> s;
        assign w_at = $signed(ZW'(atan_turns(s)));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_z[ZW-1]) begin
                    r_x[s] <= w_x - w_ys;
                    r_y[s] <= w_y + w_xs;
                    r_z[s] <= w_z - w_at;
                end else begin
                    r_x[s] <= w_x + w_ys;
                    r_y[s] <= w_y - w_xs;
                    r_z[s] <= w_z + w_at;
                end
            end
        end
    end

    assign o_x = r_x[CORDIC_STAGES-1];
    assign o_y = r_y[CORDIC_STAGES-1];
endmodule
`default_nettype wire

### src/psw_lane.sv
// One lane: distance, travel time, attenuation and phasor of a single point.
`default_nettype none
module psw_lane import psw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_cfg        i_cfg,
    input  logic [31:0] i_px,
    input  logic [31:0] i_py,
    input  logic [31:0] i_pz,
    output logic [31:0] o_re,
    output logic [31:0] o_im,
    output logic [31:0] o_mag
);
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic signed [32:0] w_dx, w_dy, w_dz;
    logic [32:0] r_ax, r_ay, r_az;
    logic [65:0] r_sqx, r_sqy, r_sqz;
    logic [SQ_IN_W-1:0] r_dsq;
    logic [SQ_IN_W-1:0] r_dsq_d [SQRT_STAGES];
    logic [SQ_ROOT_W-1:0] w_root;
    logic [SQ_IN_W+ATTEN_W-1:0] w_att;
    logic [DIV_NW-1:0] r_num_t, r_num_a;
    logic [DIV_DW-1:0] r_den_t, r_den_a;
    logic [DIV_NW-1:0] w_tt, w_qa;
    logic [31:0] w_diff;
    logic [31:0] r_prod, r_ampc;
    logic [31:0] r_ph, r_amp_n;
    logic [61:0] r_xk;
    logic [1:0] r_q_d [CORDIC_STAGES];
    logic [31:0] r_amp_d [CORDIC_STAGES];
    logic signed [CW-1:0] w_cx, w_cy;
    logic signed [CW-1:0] w_fx, w_fy;

    assign w_dx = $signed({i_px[31], i_px}) - $signed({i_cfg.src_x[31], i_cfg.src_x});
    assign w_dy = $signed({i_py[31], i_py}) - $signed({i_cfg.src_y[31], i_cfg.src_y});
    assign w_dz = $signed({i_pz[31], i_pz}) - $signed({i_cfg.src_z[31], i_cfg.src_z});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax <= w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
            r_ay <= w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
            r_az <= w_dz[32] ? 33'(-w_dz) : 33'(w_dz);
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            r_sqz <= r_az * r_az;
            r_dsq <= r_sqx + r_sqy + r_sqz;
        end
    end

    psw_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(i_en), .i_rad(r_dsq), .o_root(w_root)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dsq_d[0] <= r_dsq;
            for (int i = 1; i < SQRT_STAGES; i++) begin
                r_dsq_d[i] <= r_dsq_d[i-1];
            end
        end
    end

    assign w_att = r_dsq_d[SQRT_STAGES-1] * ATTEN_Q16;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num_t <= DIV_NW'({w_root, 16'h0000});
            r_den_t <= (i_cfg.speed == 32'h0) ? DIV_DW'(1) : DIV_DW'(i_cfg.speed);
            r_num_a <= DIV_NW'({i_cfg.amp, 16'h0000});
            r_den_a <= DIV_DW'(w_att[SQ_IN_W+ATTEN_W-1:32]) + DIV_DW'(65536);
        end
    end

    psw_div u_div_t (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_num_t), .i_den(r_den_t), .o_quo(w_tt)
    );

    psw_div u_div_a (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_num_a), .i_den(r_den_a), .o_quo(w_qa)
    );

    assign w_diff = i_cfg.sim_time - w_tt[31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_cfg.freq * w_diff;
            r_ampc <= (|w_qa[DIV_NW-1:32]) ? 32'hFFFFFFFF : w_qa[31:0];
            r_ph <= r_prod + {i_cfg.offset, 16'h0000};
            r_xk <= r_ampc * CORDIC_GAIN_Q30;
            r_amp_n <= r_ampc;
        end
    end

    psw_cordic u_cordic (
        .i_clk(i_clk), .i_en(i_en), .i_x0(r_xk[61:30]), .i_z0(r_ph[29:0]),
        .o_x(w_cx), .o_y(w_cy)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_d[0] <= r_ph[31:30];
            r_amp_d[0] <= r_amp_n;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                r_q_d[i] <= r_q_d[i-1];
                r_amp_d[i] <= r_amp_d[i-1];
            end
        end
    end

    always_comb begin
        case (r_q_d[CORDIC_STAGES-1])
            QUAD_0: begin
                w_fx = w_cx;
                w_fy = w_cy;
            end
            QUAD_1: begin
                w_fx = -w_cy;
                w_fy = w_cx;
            end
            QUAD_2: begin
                w_fx = -w_cx;
                w_fy = -w_cy;
            end
            QUAD_3: begin
                w_fx = w_cy;
                w_fy = -w_cx;
            end
            default: begin
                w_fx = w_cx;
                w_fy = w_cy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_re <= sat32(w_fx);
            o_im <= sat32(w_fy);
            o_mag <= r_amp_d[CORDIC_STAGES-1];
        end
    end
endmodule
`default_nettype wire

### src/point_source_wave_contribution_unit.sv
// Top level of the point-source wave contribution unit: configuration, lanes and output stage.
// The unit takes one request of four points per clock and returns one request of four
// phasors and amplitudes per clock while the output is not stalled. Each lane's
// pipeline holds a 34-stage square root, two 49-stage dividers working side by
// side, and a 24-stage CORDIC, plus seven arithmetic stages, followed by the output register.
// A stall on the output holds the whole pipeline.
`default_nettype none
module point_source_wave_contribution_unit import psw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_p0_x,
    input  logic [31:0] i_p0_y,
    input  logic [31:0] i_p0_z,
    input  logic [31:0] i_p1_x,
    input  logic [31:0] i_p1_y,
    input  logic [31:0] i_p1_z,
    input  logic [31:0] i_p2_x,
    input  logic [31:0] i_p2_y,
    input  logic [31:0] i_p2_z,
    input  logic [31:0] i_p3_x,
    input  logic [31:0] i_p3_y,
    input  logic [31:0] i_p3_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_c0_re,
    output logic [31:0] o_c0_im,
    output logic [31:0] o_a0_mag,
    output logic [31:0] o_c1_re,
    output logic [31:0] o_c1_im,
    output logic [31:0] o_a1_mag,
    output logic [31:0] o_c2_re,
    output logic [31:0] o_c2_im,
    output logic [31:0] o_a2_mag,
    output logic [31:0] o_c3_re,
    output logic [31:0] o_c3_im,
    output logic [31:0] o_a3_mag
);
    t_cfg r_cfg;
    logic [LANE_LAT-1:0] r_vpipe;
    logic r_out_valid;
    logic w_en;
    logic [31:0] w_px [NUM_SLOTS];
    logic [31:0] w_py [NUM_SLOTS];
    logic [31:0] w_pz [NUM_SLOTS];
    logic [31:0] w_re [NUM_SLOTS];
    logic [31:0] w_im [NUM_SLOTS];
    logic [31:0] w_mag [NUM_SLOTS];
    logic [31:0] r_re [NUM_SLOTS];
    logic [31:0] r_im [NUM_SLOTS];
    logic [31:0] r_mag [NUM_SLOTS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_x <= 32'h0;
            r_cfg.src_y <= 32'h0;
            r_cfg.src_z <= 32'h0;
            r_cfg.freq <= 32'h00010000;
            r_cfg.offset <= 16'h0;
            r_cfg.amp <= 32'h00010000;
            r_cfg.speed <= 32'h00010000;
            r_cfg.sim_time <= 32'h0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_X: r_cfg.src_x <= i_cfg_data;
                CFG_SRC_Y: r_cfg.src_y <= i_cfg_data;
                CFG_SRC_Z: r_cfg.src_z <= i_cfg_data;
                CFG_FREQ: r_cfg.freq <= i_cfg_data;
                CFG_OFFSET: r_cfg.offset <= i_cfg_data[15:0];
                CFG_AMP: r_cfg.amp <= i_cfg_data;
                CFG_SPEED: r_cfg.speed <= i_cfg_data;
                CFG_TIME: r_cfg.sim_time <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_en = !r_out_valid || i_ready;
    assign o_ready = w_en;

    assign w_px[0] = i_p0_x;
    assign w_py[0] = i_p0_y;
    assign w_pz[0] = i_p0_z;
    assign w_px[1] = i_p1_x;
    assign w_py[1] = i_p1_y;
    assign w_pz[1] = i_p1_z;
    assign w_px[2] = i_p2_x;
    assign w_py[2] = i_p2_y;
    assign w_pz[2] = i_p2_z;
    assign w_px[3] = i_p3_x;
    assign w_py[3] = i_p3_y;
    assign w_pz[3] = i_p3_z;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_lane
        if (k < LANES) begin : g_on
            psw_lane u_lane (
                .i_clk(i_clk), .i_en(w_en), .i_cfg(r_cfg),
                .i_px(w_px[k]), .i_py(w_py[k]), .i_pz(w_pz[k]),
                .o_re(w_re[k]), .o_im(w_im[k]), .o_mag(w_mag[k])
            );
        end else begin : g_off
            assign w_re[k] = 32'h0;
            assign w_im[k] = 32'h0;
            assign w_mag[k] = 32'h0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vpipe <= {r_vpipe[LANE_LAT-2:0], i_valid};
            r_out_valid <= r_vpipe[LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_re[k] <= w_re[k];
                r_im[k] <= w_im[k];
                r_mag[k] <= w_mag[k];
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_c0_re = r_re[0];
    assign o_c0_im = r_im[0];
    assign o_a0_mag = r_mag[0];
    assign o_c1_re = r_re[1];
    assign o_c1_im = r_im[1];
    assign o_a1_mag = r_mag[1];
    assign o_c2_re = r_re[2];
    assign o_c2_im = r_im[2];
    assign o_a2_mag = r_mag[2];
    assign o_c3_re = r_re[3];
    assign o_c3_im = r_im[3];
    assign o_a3_mag = r_mag[3];

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vpipe) && r_out_valid)
        else $error("pipeline moved during an output stall");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && (r_vpipe == '0))
        else $error("valid state not cleared by reset");

    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_mag[0] <= r_cfg.amp))
        else $error("attenuated amplitude exceeds source amplitude");
endmodule
`default_nettype wire

### test/point_source_wave_contribution_unit_tb.sv
// Self-checking testbench of the point-source wave contribution unit with a built-in predictor.
`default_nettype none
module point_source_wave_contribution_unit_tb;
    import psw_pkg::*;

    typedef struct {
        logic [31:0] x[4];
        logic [31:0] y[4];
        logic [31:0] z[4];
    } t_point_set;

    typedef struct {
        logic [31:0] re[4];
        logic [31:0] im[4];
        logic [31:0] mag[4];
    } t_phasor_set;

    localparam logic [31:0] ARC_TURNS[24] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] px[4] = '{default: '0};
    logic [31:0] py[4] = '{default: '0};
    logic [31:0] pz[4] = '{default: '0};
    logic [31:0] o_re[4];
    logic [31:0] o_im[4];
    logic [31:0] o_mag[4];

    t_cfg        shadow_cfg;
    t_point_set  pending_points[$];
    t_phasor_set expected_phasors[$];
    t_point_set  offered;
    int          mismatches = 0;
    int          results_seen = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    int          hold_cycles = 0;
    bit          hold_done = 0;
    int          phase_idx;

    point_source_wave_contribution_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_p0_x(px[0]), .i_p0_y(py[0]), .i_p0_z(pz[0]),
        .i_p1_x(px[1]), .i_p1_y(py[1]), .i_p1_z(pz[1]),
        .i_p2_x(px[2]), .i_p2_y(py[2]), .i_p2_z(pz[2]),
        .i_p3_x(px[3]), .i_p3_y(py[3]), .i_p3_z(pz[3]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_c0_re(o_re[0]), .o_c0_im(o_im[0]), .o_a0_mag(o_mag[0]),
        .o_c1_re(o_re[1]), .o_c1_im(o_im[1]), .o_a1_mag(o_mag[1]),
        .o_c2_re(o_re[2]), .o_c2_im(o_im[2]), .o_a2_mag(o_mag[2]),
        .o_c3_re(o_re[3]), .o_c3_im(o_im[3]), .o_a3_mag(o_mag[3])
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] clamp_s32(input longint v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic void lane_contribution(input t_cfg c, input logic [31:0] qx,
                                              input logic [31:0] qy, input logic [31:0] qz,
                                              output logic [31:0] re, output logic [31:0] im,
                                              output logic [31:0] mag);
        logic signed [32:0] dx, dy, dz;
        logic [32:0] ax, ay, az;
        logic [65:0] dsq;
        logic [33:0] root, cand;
        logic [67:0] sq;
        logic [49:0] travel;
        logic [31:0] spd, lag, ph;
        logic [72:0] scaled;
        logic [41:0] den;
        logic [47:0] quot;
        logic [61:0] gained;
        longint x, y, z, xs, ys, t;
        dx = $signed({qx[31], qx}) - $signed({c.src_x[31], c.src_x});
        dy = $signed({qy[31], qy}) - $signed({c.src_y[31], c.src_y});
        dz = $signed({qz[31], qz}) - $signed({c.src_z[31], c.src_z});
        ax = dx[32] ? -dx : dx;
        ay = dy[32] ? -dy : dy;
        az = dz[32] ? -dz : dz;
        dsq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay) + 66'(az) * 66'(az);
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (34'd1 << b);
            sq = 68'(cand) * 68'(cand);
            if (sq <= 68'(dsq)) root = cand;
        end
        spd = (c.speed == 0) ? 32'd1 : c.speed;
        travel = {root, 16'h0} / 50'(spd);
        lag = c.sim_time - travel[31:0];
        ph = c.freq * lag + {c.offset, 16'h0};
        scaled = 73'(dsq) * 73'(ATTEN_Q16);
        den = 42'd65536 + 42'(scaled[72:32]);
        quot = {c.amp, 16'h0} / 48'(den);
        mag = (quot[47:32] != 0) ? 32'hFFFFFFFF : quot[31:0];
        gained = 62'(mag) * 62'(CORDIC_GAIN_Q30);
        x = longint'(gained[61:30]);
        y = 0;
        z = longint'(ph[29:0]);
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(ARC_TURNS[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(ARC_TURNS[i]);
            end
        end
        case (ph[31:30])
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        re = clamp_s32(x);
        im = clamp_s32(y);
    endfunction

    function automatic t_phasor_set wave_contribution(input t_cfg c, input t_point_set s);
        t_phasor_set r;
        for (int k = 0; k < 4; k++) begin
            if (k < LANES) begin
                lane_contribution(c, s.x[k], s.y[k], s.z[k], r.re[k], r.im[k], r.mag[k]);
            end else begin
                r.re[k] = '0; r.im[k] = '0; r.mag[k] = '0;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] coord(input logic [31:0] centre, input int mode);
        logic [31:0] v;
        case (mode)
            0: v = $urandom;
            1: v = centre + $urandom_range(0, 32'h3FFFF) - 32'h20000;
            2: v = centre + $urandom_range(0, 32'h3FFFFFF) - 32'h2000000;
            default: v = centre;
        endcase
        return v;
    endfunction

    // Requests cluster around the source most of the time so distances stay in a useful range.
    task automatic queue_random(input int count);
        t_point_set s;
        int m;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 4; k++) begin
                m = $urandom_range(0, 9);
                m = (m < 3) ? 0 : (m < 6) ? 1 : (m < 9) ? 2 : 3;
                s.x[k] = coord(shadow_cfg.src_x, m);
                s.y[k] = coord(shadow_cfg.src_y, m);
                s.z[k] = coord(shadow_cfg.src_z, m);
            end
            pending_points = {pending_points, s};
        end
    endtask

    task automatic queue_uniform(input logic [31:0] v);
        t_point_set s;
        for (int k = 0; k < 4; k++) begin
            s.x[k] = v; s.y[k] = v; s.z[k] = v;
        end
        pending_points = {pending_points, s};
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_SRC_X: shadow_cfg.src_x = data;
            CFG_SRC_Y: shadow_cfg.src_y = data;
            CFG_SRC_Z: shadow_cfg.src_z = data;
            CFG_FREQ: shadow_cfg.freq = data;
            CFG_OFFSET: shadow_cfg.offset = data[15:0];
            CFG_AMP: shadow_cfg.amp = data;
            CFG_SPEED: shadow_cfg.speed = data;
            default: shadow_cfg.sim_time = data;
        endcase
    endtask

    task automatic write_all(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sz, input logic [31:0] f,
                             input logic [31:0] off, input logic [31:0] a,
                             input logic [31:0] sp, input logic [31:0] tm);
        write_reg(CFG_SRC_X, sx);
        write_reg(CFG_SRC_Y, sy);
        write_reg(CFG_SRC_Z, sz);
        write_reg(CFG_FREQ, f);
        write_reg(CFG_OFFSET, off);
        write_reg(CFG_AMP, a);
        write_reg(CFG_SPEED, sp);
        write_reg(CFG_TIME, tm);
    endtask

    task automatic drain;
        while (pending_points.size() != 0 || i_valid || expected_phasors.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LANE_LAT + 10) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        bit nv;
        int c;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nv = i_valid;
            if (i_valid && o_ready) begin
                expected_phasors = {expected_phasors, wave_contribution(shadow_cfg, offered)};
                nv = 0;
                c = $urandom_range(0, 3);
                send_gap = (c == 0) ? $urandom_range(0, 16) : 0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_points.size() != 0) begin
                    offered = pending_points.pop_front();
                    nv = 1;
                    for (int k = 0; k < 4; k++) begin
                        px[k] <= offered.x[k];
                        py[k] <= offered.y[k];
                        pz[k] <= offered.z[k];
                    end
                end
            end
            i_valid <= nv;
        end
    end

    // The receiver holds off once for a long stretch so that the block fills and stalls.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
        end else if (!hold_done && results_seen >= 500) begin
            hold_cycles = 400;
            hold_done = 1;
        end
    end

    always @(posedge i_clk) begin
        t_phasor_set e;
        bit bad;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_phasors.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result request at %0t", $realtime);
                end else begin
                    e = expected_phasors.pop_front();
                    bad = 0;
                    for (int k = 0; k < 4; k++) begin
                        if (o_re[k] !== e.re[k] || o_im[k] !== e.im[k]
                                || o_mag[k] !== e.mag[k]) begin
                            bad = 1;
                            if (mismatches < 10) begin
                                $display("lane %0d: expected re %h im %h mag %h, got re %h im %h mag %h",
                                         k, e.re[k], e.im[k], e.mag[k],
                                         o_re[k], o_im[k], o_mag[k]);
                            end
                        end
                    end
                    if (bad) mismatches++;
                end
                recv_stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            end
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        shadow_cfg = '{src_x: 32'h0, src_y: 32'h0, src_z: 32'h0, freq: 32'h10000,
                       offset: 16'h0, amp: 32'h10000, speed: 32'h10000, sim_time: 32'h0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_uniform(32'h00000000);
        queue_uniform(32'h7FFFFFFF);
        queue_uniform(32'h80000000);
        queue_uniform(32'hFFFFFFFF);
        queue_uniform(32'h00010000);
        queue_uniform(32'hFFFF0000);
        queue_uniform(32'h00000001);
        queue_random(300);
        drain();

        write_all(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
                  32'h0000FFFF, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF);
        queue_uniform(32'h80000000);
        queue_uniform(32'h7FFFFFFF);
        queue_uniform(32'h00000000);
        queue_random(250);
        drain();

        write_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00000000,
                  32'h00008000, 32'h00000000, 32'hFFFFFFFF, 32'h00000000);
        queue_uniform(32'h7FFFFFFF);
        queue_uniform(32'h80000000);
        queue_random(200);
        drain();

        write_all(32'h00000000, 32'h00000000, 32'h00000000, 32'h00010000,
                  32'h00000000, 32'hFFFFFFFF, 32'h00000001, 32'h00000000);
        queue_uniform(32'h00000000);
        queue_random(200);
        drain();

        for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
            write_all($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 16'hFFFF),
                      $urandom, $urandom_range(1, 32'hFFFFFFFF), $urandom);
            queue_random(190);
            drain();
        end

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
src/psw_pkg.sv
src/psw_sqrt.sv
src/psw_div.sv
src/psw_cordic.sv
src/psw_lane.sv
src/point_source_wave_contribution_unit.sv
test/point_source_wave_contribution_unit_tb.sv
